/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; clock and reset names follow the project convention
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define PCRW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on aclk, off while in reset
`define PCRW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/pcrw_pkg.sv */
// shared types and constants for the page-column raster writer
// no dependencies
package pcrw_pkg;

    // geometry of the display
    localparam int DEF_PAGES = 8;
    localparam int COLUMNS   = 128;
    localparam int ROW_BYTES = COLUMNS / 8;
    localparam int COL_W     = 7;
    localparam int CB_W      = 4;

    // operation codes of an input word
    typedef enum logic [1:0] {
        OP_SELECT = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    // strip write command from the controller to the row banks
    typedef struct packed {
        logic            en;
        logic [CB_W-1:0] col_byte;
        logic [7:0]      mask;
        logic [7:0]      data;
    } wr_cmd_t;

    // status carried with each result word
    typedef struct packed {
        logic             taken;
        logic [3:0]       page;
        logic [COL_W-1:0] column;
    } status_t;

endpackage

/* rtl/core/pcrw_bank.sv */
// one row bank of the raster: byte wide, bit-maskable write, registered read
// depends on nothing outside this file
module pcrw_bank #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wmask,
    input  logic          wbit,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // masked write: only the selected pixel bits change
    always_ff @(posedge aclk) begin
        if (we) begin
            for (int i = 0; i < 8; i++) begin
                if (wmask[i]) begin
                    mem[waddr][i] <= wbit;
                end
            end
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/pcrw_ctrl.sv */
// page and column registers and per-word command decode
// depends on pcrw_pkg
module pcrw_ctrl #(
    parameter int PAGES = pcrw_pkg::DEF_PAGES,
    parameter int PG_W  = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [1:0]        operation,
    input  logic [2:0]        page_number,
    input  logic [7:0]        data_byte,
    output logic [PG_W-1:0]   page_idx,
    output pcrw_pkg::wr_cmd_t wr_cmd,
    output pcrw_pkg::status_t status
);
    import pcrw_pkg::*;

    localparam int PX_W = PG_W + 4;

    logic [PG_W-1:0]  page_reg, page_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             taken;
    logic [PX_W-1:0]  page_ext;

    // next page and column, strip write command
    always_comb begin
        page_next      = page_reg;
        col_next       = col_reg;
        taken          = 1'b0;
        wr_cmd.en      = 1'b0;
        wr_cmd.col_byte = col_reg[COL_W-1:3];
        wr_cmd.mask    = 8'h80 >> col_reg[2:0];
        wr_cmd.data    = data_byte;
        case (op_t'(operation))
            OP_SELECT: begin
                page_next = PG_W'(page_number);
                col_next  = '0;
            end
            OP_WRITE: begin
                if (page_reg < PG_W'(PAGES)) begin
                    wr_cmd.en = 1'b1;
                    taken     = 1'b1;
                    if (col_reg == COL_W'(COLUMNS - 1)) begin
                        col_next  = '0;
                        page_next = page_reg + 1'b1;
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            OP_READ: begin
                page_next = page_reg;
            end
            default: begin
                page_next = page_reg;
            end
        endcase
    end

    // page and column state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_reg <= '0;
            col_reg  <= '0;
        end else if (accept) begin
            page_reg <= page_next;
            col_reg  <= col_next;
        end
    end

    // reported page is masked to the four-bit field
    assign page_ext      = PX_W'(page_next);
    assign status.taken  = taken;
    assign status.page   = page_ext[3:0];
    assign status.column = col_next;
    assign page_idx      = page_reg;

endmodule

/* rtl/core/page_column_to_raster_writer.sv */
// top level of the page-column raster writer: clear sweep, row banks, pipeline
// depends on pcrw_pkg, pcrw_ctrl, pcrw_bank
//
//  port group   dir  handshake          payload
//  s_*          in   s_valid/s_ready    operation, page_number, data_byte, raster_address
//  m_*          out  m_valid/m_ready    read_byte, write_taken, current_page, current_column
//
// one word accepted per cycle while s_ready is high; results pass the bank read stage
// the raster sits in eight row banks written and read in the accept cycle
// after reset a sweep clears all PAGES*16 bank entries (128 at default) with s_ready low
// a stalled result holds the bank read stage; s_ready then drops once that stage is full
module page_column_to_raster_writer #(
    parameter int PAGES = pcrw_pkg::DEF_PAGES
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_operation,
    input  logic [2:0]                s_page_number,
    input  logic [7:0]                s_data_byte,
    input  logic [9:0]                s_raster_address,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_read_byte,
    output logic                      m_write_taken,
    output logic [3:0]                m_current_page,
    output logic [pcrw_pkg::COL_W-1:0] m_current_column
);
    import pcrw_pkg::*;

    localparam int DEPTH  = PAGES * ROW_BYTES;
    localparam int BA_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PG_RAW = $clog2(PAGES + 1);
    localparam int PG_W   = (PG_RAW < 3) ? 3 : PG_RAW;
    localparam int STORE  = PAGES * 8 * ROW_BYTES;

    logic            clr_active_reg;
    logic [BA_W-1:0] clr_addr_reg;
    logic            accept;
    logic            a_move;
    logic [PG_W-1:0] page_idx;
    wr_cmd_t         wr_cmd;
    status_t         status;
    logic            bank_we;
    logic [BA_W-1:0] bank_waddr;
    logic [7:0]      bank_wmask;
    logic            bank_re;
    logic [BA_W-1:0] bank_raddr;
    logic [7:0]      bank_rdata [8];
    logic            rd_ok;

    logic            a_valid_reg;
    logic            a_rd_reg;
    logic [2:0]      a_bank_reg;
    status_t         a_status_reg;

    logic             m_valid_reg;
    logic [7:0]       m_read_byte_reg;
    logic [7:0]       m_read_byte_next;
    status_t          m_status_reg;

    // clearing sweep over all bank entries after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == BA_W'(DEPTH - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // handshake
    assign a_move  = !m_valid_reg || m_ready;
    assign s_ready = !clr_active_reg && (!a_valid_reg || a_move);
    assign accept  = s_valid && s_ready;

    pcrw_ctrl #(
        .PAGES (PAGES),
        .PG_W  (PG_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .operation   (s_operation),
        .page_number (s_page_number),
        .data_byte   (s_data_byte),
        .page_idx    (page_idx),
        .wr_cmd      (wr_cmd),
        .status      (status)
    );

    // bank port drive: clear sweep or strip write, read at the accepted address
    assign bank_we    = clr_active_reg || (accept && wr_cmd.en);
    assign bank_waddr = clr_active_reg ? clr_addr_reg : BA_W'({page_idx, wr_cmd.col_byte});
    assign bank_wmask = clr_active_reg ? 8'hFF : wr_cmd.mask;
    assign rd_ok      = (s_operation == OP_READ) && ({2'b00, s_raster_address} < 12'(STORE));
    assign bank_re    = accept && rd_ok;
    assign bank_raddr = BA_W'({s_raster_address[9:7], s_raster_address[3:0]});

    // one bank per row within a page
    for (genvar k = 0; k < 8; k++) begin : g_bank
        pcrw_bank #(
            .DEPTH (DEPTH),
            .AW    (BA_W)
        ) u_bank (
            .aclk  (aclk),
            .we    (bank_we),
            .waddr (bank_waddr),
            .wmask (bank_wmask),
            .wbit  (!clr_active_reg && wr_cmd.data[k]),
            .re    (bank_re),
            .raddr (bank_raddr),
            .rdata (bank_rdata[k])
        );
    end

    // bank read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (accept) begin
            a_valid_reg <= 1'b1;
        end else if (a_move) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_rd_reg     <= rd_ok;
            a_bank_reg   <= s_raster_address[6:4];
            a_status_reg <= status;
        end
    end

    // pick the row bank for a read, zero otherwise
    assign m_read_byte_next = a_rd_reg ? bank_rdata[a_bank_reg] : 8'h00;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (a_move) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_move && a_valid_reg) begin
            m_read_byte_reg <= m_read_byte_next;
            m_status_reg    <= a_status_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_read_byte      = m_read_byte_reg;
    assign m_write_taken    = m_status_reg.taken;
    assign m_current_page   = m_status_reg.page;
    assign m_current_column = m_status_reg.column;

endmodule

/* rtl/core/pcrw_checker.sv */
// port-level checks for the page-column raster writer, bound to the top level
// depends on pcrw_pkg and assert_macros.svh
`include "assert_macros.svh"

module pcrw_checker #(
    parameter int PAGES = pcrw_pkg::DEF_PAGES
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [7:0]                 m_read_byte,
    input logic                       m_write_taken,
    input logic [3:0]                 m_current_page,
    input logic [pcrw_pkg::COL_W-1:0] m_current_column
);

    localparam int CUR_W = 4 + pcrw_pkg::COL_W;

    logic [CUR_W-1:0]   cursor;
    logic [CUR_W+8:0]   m_word;
    logic               wr_word;

    // result word payload and cursor as single vectors
    assign cursor  = {m_current_page, m_current_column};
    assign m_word  = {m_read_byte, m_write_taken, cursor};
    assign wr_word = m_valid && m_write_taken;

    // a stalled result word holds
    `PCRW_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_word))

    // a write word never carries read data
    `PCRW_ASSERT_NOW(a_write_no_data, wr_word, m_read_byte == 8'h00)

    // a taken write moves the cursor off page 0 column 0 (checked when PAGES is below 16)
    `PCRW_ASSERT_NOW(a_cursor_moves, wr_word && (PAGES < 16), cursor != '0)

    // a result word appearing on an idle output came from a word taken through the bank read stage
    `PCRW_ASSERT_NOW(a_latency, $rose(m_valid), $past(s_valid && s_ready, 2))

endmodule

bind page_column_to_raster_writer pcrw_checker #(.PAGES(PAGES)) u_pcrw_checker (.*);

/* dv/page_column_to_raster_writer_test.sv */
// self-checking bench for the page-column raster writer: driver, monitor and raster predictor
// depends on pcrw_pkg and page_column_to_raster_writer
module page_column_to_raster_writer_test;
    import pcrw_pkg::*;

    // operation code the block leaves unused
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RASTER_BYTES = DEF_PAGES * 8 * ROW_BYTES;
    localparam int RANDOM_WORDS = 700;

    typedef struct {
        logic [1:0] operation;
        logic [2:0] page_number;
        logic [7:0] data_byte;
        logic [9:0] raster_address;
    } display_word_t;

    typedef struct {
        logic [7:0]       read_byte;
        logic             write_taken;
        logic [3:0]       current_page;
        logic [COL_W-1:0] current_column;
    } raster_result_t;

    logic             aclk;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [1:0]       s_operation = '0;
    logic [2:0]       s_page_number = '0;
    logic [7:0]       s_data_byte = '0;
    logic [9:0]       s_raster_address = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [7:0]       m_read_byte;
    logic             m_write_taken;
    logic [3:0]       m_current_page;
    logic [COL_W-1:0] m_current_column;

    display_word_t  pending_words[$];
    raster_result_t expected_results[$];
    int             words_taken = 0;
    int             results_seen = 0;
    int             mismatches = 0;
    int             stall_left = 0;
    logic           stall_done = 1'b0;
    logic           quiet_phase;

    // predictor state
    int         model_page = 0;
    int         model_column = 0;
    logic [7:0] model_raster [RASTER_BYTES];

    page_column_to_raster_writer i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_page_number    (s_page_number),
        .s_data_byte      (s_data_byte),
        .s_raster_address (s_raster_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_byte      (m_read_byte),
        .m_write_taken    (m_write_taken),
        .m_current_page   (m_current_page),
        .m_current_column (m_current_column)
    );

    // stretch with no idling on either side
    assign quiet_phase = (words_taken >= 400) && (words_taken < 550);

    // advance the raster model by one word and return the result it should produce
    function automatic raster_result_t apply_display_word(display_word_t w);
        raster_result_t r;
        int byte_col;
        int row_idx;
        logic [7:0] pixel_mask;
        r.read_byte   = '0;
        r.write_taken = 1'b0;
        case (w.operation)
            OP_SELECT: begin
                model_page   = int'(w.page_number);
                model_column = 0;
            end
            OP_WRITE: begin
                if (model_page < DEF_PAGES) begin
                    byte_col   = model_column / 8;
                    pixel_mask = 8'h80 >> (model_column % 8);
                    // vertical strip: bit k lands on row page*8+k
                    if (byte_col < ROW_BYTES) begin
                        for (int k = 0; k < 8; k++) begin
                            row_idx = (model_page * 8 + k) * ROW_BYTES + byte_col;
                            if (row_idx < RASTER_BYTES) begin
                                if (w.data_byte[k])
                                    model_raster[row_idx] = model_raster[row_idx] | pixel_mask;
                                else
                                    model_raster[row_idx] = model_raster[row_idx] & ~pixel_mask;
                            end
                        end
                    end
                    r.write_taken = 1'b1;
                    model_column++;
                    if (model_column >= COLUMNS) begin
                        model_column = 0;
                        model_page++;
                    end
                end
            end
            OP_READ: begin
                if (int'(w.raster_address) < RASTER_BYTES)
                    r.read_byte = model_raster[w.raster_address];
            end
            default: ;
        endcase
        r.current_page   = model_page[3:0];
        r.current_column = model_column[COL_W-1:0];
        return r;
    endfunction

    function automatic void push_word(logic [1:0] op, logic [2:0] pg, logic [7:0] data,
                                      logic [9:0] addr);
        display_word_t w;
        w.operation      = op;
        w.page_number    = pg;
        w.data_byte      = data;
        w.raster_address = addr;
        pending_words.push_back(w);
    endfunction

    // select a page, write a run of strips with reads mixed in, then read back its rows
    function automatic void add_page_run(int page, int writes);
        int last_col;
        push_word(OP_SELECT, 3'(page), 8'($urandom), 10'($urandom));
        for (int i = 0; i < writes; i++) begin
            push_word(OP_WRITE, 3'($urandom), 8'($urandom), 10'($urandom));
            if ($urandom_range(0, 7) == 0) begin
                last_col = (i > 127) ? 127 : i;
                push_word(OP_READ, 3'($urandom), 8'($urandom),
                          10'((page * 8 + $urandom_range(0, 7)) * ROW_BYTES
                              + $urandom_range(0, last_col / 8)));
            end
        end
        last_col = (writes > 128) ? 127 : writes - 1;
        for (int i = 0; i < 3; i++)
            push_word(OP_READ, 3'($urandom), 8'($urandom),
                      10'((page * 8 + $urandom_range(0, 7)) * ROW_BYTES
                          + $urandom_range(0, last_col / 8)));
    endfunction

    task automatic check_field(string field, int expected_value, int actual_value);
        if (expected_value != actual_value) begin
            $error("%s: expected %0d, got %0d", field, expected_value, actual_value);
            mismatches++;
        end
    endtask

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // reset, asserted at start and released once
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // run limit
    initial begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    // input word driver
    always @(posedge aclk) begin
        display_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_words.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 29)) begin
                w = pending_words.pop_front();
                s_valid          <= 1'b1;
                s_operation      <= w.operation;
                s_page_number    <= w.page_number;
                s_data_byte      <= w.data_byte;
                s_raster_address <= w.raster_address;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver: random idling plus one long hold-off that backs the block up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!stall_done && results_seen >= 300) begin
            stall_done <= 1'b1;
            stall_left <= 250;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= quiet_phase || ($urandom_range(0, 99) >= 29);
        end
    end

    // monitor: predict on each accepted input word, check each accepted result word
    always @(posedge aclk) begin
        display_word_t  taken_word;
        raster_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                taken_word = '{s_operation, s_page_number, s_data_byte, s_raster_address};
                expected_results.push_back(apply_display_word(taken_word));
                words_taken <= words_taken + 1;
            end
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("result word with no expectation waiting");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_byte", want.read_byte, m_read_byte);
                    check_field("write_taken", want.write_taken, m_write_taken);
                    check_field("current_page", want.current_page, m_current_page);
                    check_field("current_column", want.current_column, m_current_column);
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        int kind;
        int directed_count;
        for (int i = 0; i < RASTER_BYTES; i++)
            model_raster[i] = 8'h00;

        // directed: cleared store, strip bits, unused code, top page, field extremes
        push_word(OP_READ, 3'd0, 8'h00, 10'd0);
        push_word(OP_READ, 3'd7, 8'hff, 10'd1023);
        push_word(OP_SELECT, 3'd0, 8'h00, 10'd0);
        push_word(OP_WRITE, 3'd0, 8'hff, 10'd0);
        push_word(OP_WRITE, 3'd7, 8'h00, 10'd1023);
        push_word(OP_WRITE, 3'd0, 8'h80, 10'd0);
        push_word(OP_WRITE, 3'd0, 8'h01, 10'd0);
        push_word(OP_WRITE, 3'd0, 8'ha5, 10'd0);
        push_word(OP_READ, 3'd0, 8'h00, 10'd0);
        push_word(OP_READ, 3'd0, 8'h00, 10'(7 * ROW_BYTES));
        push_word(OP_READ, 3'd0, 8'h00, 10'(1 * ROW_BYTES));
        push_word(OP_UNUSED, 3'd7, 8'hff, 10'd1023);
        push_word(OP_SELECT, 3'd7, 8'hff, 10'd1023);
        push_word(OP_WRITE, 3'd0, 8'h5a, 10'd0);
        push_word(OP_READ, 3'd0, 8'h00, 10'(56 * ROW_BYTES));
        push_word(OP_READ, 3'd0, 8'h00, 10'd1023);
        push_word(OP_SELECT, 3'd3, 8'h00, 10'd0);
        push_word(OP_WRITE, 3'd0, 8'hff, 10'd0);
        push_word(OP_READ, 3'd0, 8'h00, 10'(24 * ROW_BYTES));
        push_word(OP_UNUSED, 3'd0, 8'h00, 10'd0);
        directed_count = pending_words.size();

        // wrap off the last page and keep writing past the end
        add_page_run(7, $urandom_range(129, 180));
        // random runs with random content, plus noise
        while (pending_words.size() < directed_count + RANDOM_WORDS) begin
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                add_page_run($urandom_range(5, 7), $urandom_range(129, 180));
            end else if (kind < 70) begin
                add_page_run($urandom_range(0, 7), $urandom_range(1, 24));
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 4))
                    push_word(OP_READ, 3'($urandom), 8'($urandom), 10'($urandom));
            end else begin
                repeat ($urandom_range(1, 4))
                    push_word(2'($urandom_range(0, 3)), 3'($urandom), 8'($urandom),
                              10'($urandom));
            end
        end

        // drain: all words sent, all results back, then a short tail
        @(posedge aclk);
        while (pending_words.size() > 0 || s_valid)
            @(posedge aclk);
        while (expected_results.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
